FILE: hw/rtl/led_matrix_digit_scroll_scanner_unit_defines.svh
// assertion macros for the led matrix digit scroll scanner
// used by led_matrix_digit_scroll_scanner_unit; no other dependencies
`ifndef LED_MATRIX_DIGIT_SCROLL_SCANNER_UNIT_DEFINES_SVH
`define LED_MATRIX_DIGIT_SCROLL_SCANNER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge outside reset
`define LMDSS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("scanner assertion failed");

// antecedent implies consequent in the same cycle
`define LMDSS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// antecedent implies consequent in the next cycle
`define LMDSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`else

`define LMDSS_ASSERT_ALWAYS(label, clk, rst, cond)
`define LMDSS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LMDSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/lmdss_pkg.sv
// shared constants, font table and types for the led matrix digit scroll scanner
// no dependencies
package lmdss_pkg;

   localparam int TENS_W   = 3;
   localparam int ONES_W   = 4;
   localparam int DRIVE_W  = 8;
   localparam int COUNT_W  = 4;
   localparam int INDEX_W  = 1;
   localparam int CSR_W    = 4;
   localparam int REQ_W    = 8;
   localparam int RSP_W    = 16;
   localparam int RSP_USER_W = 2;

   localparam logic [INDEX_W-1:0] CSR_REFRESHES_PER_FRAME = 1'd0;
   localparam logic [INDEX_W-1:0] CSR_SCROLL_ENABLE       = 1'd1;

   localparam logic [COUNT_W-1:0] REFRESHES_RESET = 4'd10;

   typedef logic [DRIVE_W-1:0] font_row_type;

   localparam font_row_type FONT_ROM [10][8] = '{
      '{8'h70, 8'h88, 8'hC8, 8'hA8, 8'h98, 8'h88, 8'h70, 8'h00},
      '{8'h20, 8'h30, 8'h20, 8'h20, 8'h20, 8'h20, 8'hF8, 8'h00},
      '{8'h70, 8'h88, 8'h80, 8'h40, 8'h20, 8'h10, 8'hF8, 8'h00},
      '{8'hF8, 8'h40, 8'h20, 8'h40, 8'h80, 8'h88, 8'h70, 8'h00},
      '{8'h40, 8'h60, 8'h50, 8'h48, 8'hF8, 8'h40, 8'h40, 8'h00},
      '{8'hF8, 8'h08, 8'h78, 8'h80, 8'h80, 8'h88, 8'h70, 8'h00},
      '{8'h60, 8'h10, 8'h08, 8'h78, 8'h88, 8'h88, 8'h70, 8'h00},
      '{8'hF8, 8'h80, 8'h40, 8'h20, 8'h10, 8'h10, 8'h10, 8'h00},
      '{8'h70, 8'h88, 8'h88, 8'h70, 8'h88, 8'h88, 8'h70, 8'h00},
      '{8'h70, 8'h88, 8'h88, 8'hF0, 8'h80, 8'h40, 8'h30, 8'h00}
   };

   // blank for digits past nine
   function automatic font_row_type glyph_row(logic [ONES_W-1:0] digit, logic [2:0] row);
      font_row_type result;
      result = '0;
      if (digit < 4'd10) begin
         result = FONT_ROM[digit][row];
      end
      return result;
   endfunction

endpackage

FILE: hw/rtl/led_matrix_digit_scroll_scanner_unit.sv
// led matrix digit scroll scanner: top level, scan counters, scroll control and font lookup
// depends on lmdss_pkg and led_matrix_digit_scroll_scanner_unit_defines.svh
//
// Usage:
//   Each transaction on the req_ channel is one row slot and carries the BCD seconds
//   digits. For every accepted transaction the block returns exactly one transaction on
//   the rsp_ channel with the active-low row select and column pattern for that slot and
//   a flag saying which matrix (tens on the left, ones on the right) to enable.
//   A scan is GLYPH_ROWS rows of the left matrix then GLYPH_ROWS rows of the right one;
//   refreshes_per_frame scans make a frame. A tens change seen at a frame end scrolls in
//   over GLYPH_ROWS frames when scroll_enable is set.
//   rsp_tvalid rises in the cycle after req acceptance. One transaction is taken
//   every cycle while the receiver does not stall; the scan counters and font lookup are
//   combinational between the state registers and the rsp output register.
//   When the receiver stalls, the result holds in the output register and req_tready
//   drops until it is taken; a new request is taken in the same cycle the held result
//   leaves.
//   Reset clears the scan and scroll state, empties the output register and loads
//   refreshes_per_frame with 10 and scroll_enable with 1. csr_ writes take effect at
//   once; the user must make them only while the block is idle; the block does not enforce this.
`include "led_matrix_digit_scroll_scanner_unit_defines.svh"

module led_matrix_digit_scroll_scanner_unit #(
   parameter int GLYPH_ROWS = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lmdss_pkg::REQ_W-1:0]          req_tdata,  // seconds_tens, seconds_ones
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lmdss_pkg::RSP_W-1:0]          rsp_tdata,  // row_drive_n, column_drive_n
   output logic [lmdss_pkg::RSP_USER_W-1:0]     rsp_tuser,  // left_digit_enable, right_digit_enable
   input  logic                                 csr_we,
   input  logic [lmdss_pkg::INDEX_W-1:0]        csr_index,
   input  logic [lmdss_pkg::CSR_W-1:0]          csr_wdata
);

   localparam logic [3:0] ROWS = 4'(GLYPH_ROWS);

   logic [lmdss_pkg::COUNT_W-1:0] refreshes_ff, refreshes_in;
   logic                          scroll_enable_ff, scroll_enable_in;
   logic [lmdss_pkg::TENS_W-1:0]  shown_tens_ff, shown_tens_in;
   logic                          scroll_active_ff, scroll_active_in;
   logic [2:0]                    scroll_phase_ff, scroll_phase_in;
   logic [lmdss_pkg::COUNT_W-1:0] refresh_count_ff, refresh_count_in;
   logic                          digit_side_ff, digit_side_in;
   logic [2:0]                    row_index_ff, row_index_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lmdss_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [lmdss_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic [lmdss_pkg::TENS_W-1:0]  tens_in;
   logic [lmdss_pkg::ONES_W-1:0]  ones_in;
   logic                          accept;
   logic [lmdss_pkg::TENS_W-1:0]  prev_tens;
   logic [3:0]                    scroll_row;
   logic [3:0]                    row_next;
   logic [3:0]                    phase_next;
   logic [lmdss_pkg::COUNT_W-1:0] count_next;
   logic [lmdss_pkg::COUNT_W-1:0] limit;
   lmdss_pkg::font_row_type       pattern;
   logic [lmdss_pkg::DRIVE_W-1:0] row_drive_n;

   assign tens_in    = req_tdata[2:0];
   assign ones_in    = req_tdata[6:3];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // pattern for the current slot
   always_comb begin
      prev_tens  = (shown_tens_ff == '0) ? 3'd5 : shown_tens_ff - 3'd1;
      scroll_row = {1'b0, row_index_ff} + {1'b0, scroll_phase_ff};
      if (!digit_side_ff) begin
         if (scroll_active_ff) begin
            if (scroll_row < ROWS) begin
               pattern = lmdss_pkg::glyph_row({1'b0, prev_tens}, scroll_row[2:0]);
            end else begin
               pattern = lmdss_pkg::glyph_row({1'b0, shown_tens_ff},
                                              3'(scroll_row - ROWS));
            end
         end else begin
            pattern = lmdss_pkg::glyph_row({1'b0, shown_tens_ff}, row_index_ff);
         end
      end else begin
         pattern = lmdss_pkg::glyph_row(ones_in, row_index_ff);
      end
      row_drive_n = ~(8'd1 << row_index_ff);
   end

   // scan and scroll advance
   always_comb begin
      shown_tens_in    = shown_tens_ff;
      scroll_active_in = scroll_active_ff;
      scroll_phase_in  = scroll_phase_ff;
      refresh_count_in = refresh_count_ff;
      digit_side_in    = digit_side_ff;
      row_index_in     = row_index_ff;
      row_next   = {1'b0, row_index_ff} + 4'd1;
      phase_next = {1'b0, scroll_phase_ff} + 4'd1;
      count_next = refresh_count_ff + 4'd1;
      limit      = (refreshes_ff == '0) ? 4'd1 : refreshes_ff;
      if (accept) begin
         if (row_next < ROWS) begin
            row_index_in = row_next[2:0];
         end else begin
            row_index_in = '0;
            if (!digit_side_ff) begin
               digit_side_in = 1'b1;
            end else begin
               digit_side_in = 1'b0;
               if (count_next != '0 && count_next < limit) begin
                  refresh_count_in = count_next;
               end else begin
                  refresh_count_in = '0;
                  if (scroll_active_ff) begin
                     if (phase_next >= ROWS) begin
                        scroll_active_in = 1'b0;
                        scroll_phase_in  = '0;
                     end else begin
                        scroll_phase_in = phase_next[2:0];
                     end
                  end else if (tens_in != shown_tens_ff) begin
                     shown_tens_in = tens_in;
                     if (scroll_enable_ff) begin
                        scroll_active_in = 1'b1;
                        scroll_phase_in  = '0;
                     end
                  end
               end
            end
         end
      end
   end

   // output register and configuration
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {~pattern, row_drive_n};
         rsp_user_in  = {digit_side_ff, !digit_side_ff};
      end
      refreshes_in     = refreshes_ff;
      scroll_enable_in = scroll_enable_ff;
      if (csr_we) begin
         unique case (csr_index)
            lmdss_pkg::CSR_REFRESHES_PER_FRAME: refreshes_in     = csr_wdata;
            lmdss_pkg::CSR_SCROLL_ENABLE:       scroll_enable_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refreshes_ff     <= lmdss_pkg::REFRESHES_RESET;
         scroll_enable_ff <= 1'b1;
         shown_tens_ff    <= '0;
         scroll_active_ff <= 1'b0;
         scroll_phase_ff  <= '0;
         refresh_count_ff <= '0;
         digit_side_ff    <= 1'b0;
         row_index_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         refreshes_ff     <= refreshes_in;
         scroll_enable_ff <= scroll_enable_in;
         shown_tens_ff    <= shown_tens_in;
         scroll_active_ff <= scroll_active_in;
         scroll_phase_ff  <= scroll_phase_in;
         refresh_count_ff <= refresh_count_in;
         digit_side_ff    <= digit_side_in;
         row_index_ff     <= row_index_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `LMDSS_ASSERT_ALWAYS(a_row_in_range, clock, reset, {1'b0, row_index_ff} < ROWS)
   `LMDSS_ASSERT_IMPLIES(a_phase_only_scrolling, clock, reset,
      !scroll_active_ff, scroll_phase_ff == '0)
   `LMDSS_ASSERT_IMPLIES(a_rsp_one_matrix_one_row, clock, reset, rsp_tvalid,
      $onehot(rsp_tuser) && $countones(~rsp_tdata[7:0]) == 1)
   `LMDSS_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_tvalid)

endmodule
